@@ design/tts_pkg.sv @@
// tone track sequencer package: stage record type and the fixed track rom
// no dependencies
`default_nettype none
package tts_pkg;

  localparam int unsigned ClkHz   = 150000000;
  localparam int unsigned PwmDiv  = 16;
  localparam int unsigned NTracks = 5;

  localparam logic [15:0] Wrap660  = 16'(ClkHz / (PwmDiv * 660));
  localparam logic [15:0] Wrap880  = 16'(ClkHz / (PwmDiv * 880));
  localparam logic [15:0] Wrap988  = 16'(ClkHz / (PwmDiv * 988));
  localparam logic [15:0] Wrap1319 = 16'(ClkHz / (PwmDiv * 1319));

  localparam logic CmdTick = 1'b0;
  localparam logic CmdPlay = 1'b1;

  typedef struct packed {
    logic        is_tone;
    logic [15:0] wrap;
    logic [7:0]  dur_ms;
  } stage_t;

  localparam stage_t StageNone = '{is_tone: 1'b0, wrap: 16'd0, dur_ms: 8'd0};

  // number of stages in a track, invalid numbers map to track 1
  function automatic logic [1:0] track_count(input logic [2:0] trk);
    logic [1:0] c;
    case (trk)
      3'd3:    c = 2'd1;
      default: c = 2'd3;
    endcase
    return c;
  endfunction

  // stage record, invalid track maps to track 1, stage 3 maps to stage 0
  function automatic stage_t stage_rom(input logic [2:0] trk, input logic [1:0] stg);
    stage_t s;
    logic [2:0] t;
    logic [1:0] k;
    t = (trk >= 3'd1 && trk <= 3'(NTracks)) ? trk : 3'd1;
    k = (stg == 2'd3) ? 2'd0 : stg;
    s = StageNone;
    case ({t, k})
      {3'd1, 2'd0}: s = '{1'b1, Wrap660,  8'd80};
      {3'd1, 2'd1}: s = '{1'b0, 16'd0,    8'd30};
      {3'd1, 2'd2}: s = '{1'b1, Wrap880,  8'd80};
      {3'd2, 2'd0}: s = '{1'b1, Wrap880,  8'd70};
      {3'd2, 2'd1}: s = '{1'b0, 16'd0,    8'd30};
      {3'd2, 2'd2}: s = '{1'b1, Wrap660,  8'd120};
      {3'd3, 2'd0}: s = '{1'b1, Wrap880,  8'd70};
      {3'd4, 2'd0}: s = '{1'b1, Wrap988,  8'd40};
      {3'd4, 2'd1}: s = '{1'b0, 16'd0,    8'd20};
      {3'd4, 2'd2}: s = '{1'b1, Wrap1319, 8'd60};
      {3'd5, 2'd0}: s = '{1'b1, Wrap660,  8'd160};
      {3'd5, 2'd1}: s = '{1'b0, 16'd0,    8'd60};
      {3'd5, 2'd2}: s = '{1'b1, Wrap880,  8'd160};
      default:      s = StageNone;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

@@ design/tone_track_sequencer_unit.sv @@
// tone track sequencer top level: play requests, millisecond ticks, pwm wrap and duty
// depends on tts_pkg for the track rom and stage type
// an accepted item's result is written straight into the output register
// throughput: one item per cycle, limited by the output register draining and by config writes
// reset (rst_n low, synchronous): disabled, idle, held wrap zero, no result pending
// the config channel is always ready, the input item waits in a cycle with a config write
`default_nettype none
module tone_track_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,      // enabled
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [2:0] track_number
  input  wire logic        in_tuser,      // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata      // accepted, busy_res, tone_on, wrap_value, duty_level
);

  logic        enabled_r, enabled_nxt;
  logic        playing_r, playing_nxt;
  logic [2:0]  track_r, track_nxt;
  logic [1:0]  stage_r, stage_nxt;
  logic [7:0]  ms_r, ms_nxt;
  logic        tone_r, tone_nxt;
  logic [15:0] wrap_r, wrap_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [39:0] out_data_r, out_data_nxt;

  logic        in_acc, cfg_acc, acc;
  logic [2:0]  in_trk, sel_trk, next_stg;
  logic [1:0]  sel_stg;
  logic [7:0]  ms_dec;
  logic [16:0] wrap_sum;
  tts_pkg::stage_t st;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid;
  assign in_tready = (!out_valid_r || out_tready) && !cfg_valid;
  assign in_acc    = in_tvalid && in_tready;
  assign in_trk    = in_tdata[2:0];

  assign next_stg = {1'b0, stage_r} + 3'd1;
  assign sel_trk  = (in_tuser == tts_pkg::CmdPlay) ? in_trk : track_r;
  assign sel_stg  = (in_tuser == tts_pkg::CmdPlay) ? 2'd0 : next_stg[1:0];
  assign st       = tts_pkg::stage_rom(sel_trk, sel_stg);
  assign ms_dec   = (ms_r != 8'd0) ? ms_r - 8'd1 : 8'd0;

  always_comb begin
    enabled_nxt   = enabled_r;
    playing_nxt   = playing_r;
    track_nxt     = track_r;
    stage_nxt     = stage_r;
    ms_nxt        = ms_r;
    tone_nxt      = tone_r;
    wrap_nxt      = wrap_r;
    acc           = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wrap_sum      = 17'd0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_acc) begin
      enabled_nxt = cfg_data;
      playing_nxt = 1'b0;
      track_nxt   = 3'd0;
      stage_nxt   = 2'd0;
      ms_nxt      = 8'd0;
      tone_nxt    = 1'b0;
    end else if (in_acc) begin
      if (in_tuser == tts_pkg::CmdPlay) begin
        if (enabled_r && !playing_r && in_trk >= 3'd1 && in_trk <= 3'(tts_pkg::NTracks)) begin
          acc         = 1'b1;
          playing_nxt = 1'b1;
          track_nxt   = in_trk;
          stage_nxt   = 2'd0;
          ms_nxt      = st.dur_ms;
          tone_nxt    = st.is_tone;
          if (st.is_tone) begin
            wrap_nxt = st.wrap;
          end
        end
      end else if (enabled_r && playing_r) begin
        ms_nxt = ms_dec;
        if (ms_dec == 8'd0) begin
          tone_nxt = 1'b0;
          if (next_stg >= {1'b0, tts_pkg::track_count(track_r)} || next_stg > 3'd2) begin
            playing_nxt = 1'b0;
            track_nxt   = 3'd0;
            stage_nxt   = 2'd0;
            ms_nxt      = 8'd0;
          end else begin
            stage_nxt = next_stg[1:0];
            ms_nxt    = st.dur_ms;
            tone_nxt  = st.is_tone;
            if (st.is_tone) begin
              wrap_nxt = st.wrap;
            end
          end
        end
      end
      wrap_sum      = {1'b0, wrap_nxt} + 17'd1;
      out_valid_nxt = 1'b1;
      out_data_nxt  = {5'd0, wrap_sum[16:1], wrap_nxt, tone_nxt, playing_nxt, acc};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      playing_r   <= 1'b0;
      track_r     <= 3'd0;
      stage_r     <= 2'd0;
      ms_r        <= 8'd0;
      tone_r      <= 1'b0;
      wrap_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      enabled_r   <= enabled_nxt;
      playing_r   <= playing_nxt;
      track_r     <= track_nxt;
      stage_r     <= stage_nxt;
      ms_r        <= ms_nxt;
      tone_r      <= tone_nxt;
      wrap_r      <= wrap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> out_tdata[1])
    else $error("accepted item without busy");

  a_tone_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2]) |-> out_tdata[1])
    else $error("tone on while idle");

  a_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[34:19] == 16'(({1'b0, out_tdata[18:3]} + 17'd1) >> 1)))
    else $error("duty level does not match wrap");

  a_idle_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    !enabled_r |-> !playing_r)
    else $error("playing while disabled");

  a_track_valid: assert property (@(posedge clk) disable iff (!rst_n)
    playing_r |-> (track_r == 3'd1 || track_r == 3'd2 || track_r == 3'd3 ||
                   track_r == 3'd4 || track_r == 3'd5))
    else $error("playing an invalid track");

endmodule
`default_nettype wire

@@ tb/sv/tone_track_sequencer_unit_tb.sv @@
// testbench for tone_track_sequencer_unit: play requests and millisecond ticks against a
// predictor of the track rom, countdown and held pwm wrap, checked item by item
// depends on tts_pkg for the command codes
`timescale 1ns / 100ps
module tone_track_sequencer_unit_tb;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned NPhases    = 5;

  localparam logic [15:0] Tone660  = 16'(150000000 / (16 * 660));
  localparam logic [15:0] Tone880  = 16'(150000000 / (16 * 880));
  localparam logic [15:0] Tone988  = 16'(150000000 / (16 * 988));
  localparam logic [15:0] Tone1319 = 16'(150000000 / (16 * 1319));

  typedef struct packed {
    logic        cmd;
    logic [2:0]  trk;
  } play_item_t;

  typedef struct packed {
    logic        accepted;
    logic        busy;
    logic        tone_on;
    logic [15:0] wrap;
    logic [15:0] duty;
  } tone_result_t;

  typedef struct packed {
    logic        tone;
    logic [15:0] wrap;
    logic [7:0]  dur;
  } stage_rec_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_data   = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  play_item_t   pending_items[$];
  tone_result_t expected_tones[$];
  int unsigned  items_queued  = 0;
  int unsigned  results_seen  = 0;
  int unsigned  fail_count    = 0;
  int unsigned  idle_cycles   = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  logic         in_taken      = 1'b0;

  // predictor state
  logic         en_reg;
  logic         is_playing;
  logic [2:0]   trk_now;
  logic [1:0]   stage_now;
  logic [7:0]   ms_count;
  logic         tone_now;
  logic [15:0]  wrap_hold;

  tone_track_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic stage_rec_t track_stage(input logic [2:0] trk, input logic [1:0] idx);
    stage_rec_t s;
    logic [2:0] t;
    logic [1:0] k;
    t = (trk >= 3'd1 && trk <= 3'd5) ? trk : 3'd1;
    k = (idx == 2'd3) ? 2'd0 : idx;
    s = '{tone: 1'b0, wrap: 16'd0, dur: 8'd0};
    case ({t, k})
      {3'd1, 2'd0}: s = '{1'b1, Tone660,  8'd80};
      {3'd1, 2'd1}: s = '{1'b0, 16'd0,    8'd30};
      {3'd1, 2'd2}: s = '{1'b1, Tone880,  8'd80};
      {3'd2, 2'd0}: s = '{1'b1, Tone880,  8'd70};
      {3'd2, 2'd1}: s = '{1'b0, 16'd0,    8'd30};
      {3'd2, 2'd2}: s = '{1'b1, Tone660,  8'd120};
      {3'd3, 2'd0}: s = '{1'b1, Tone880,  8'd70};
      {3'd4, 2'd0}: s = '{1'b1, Tone988,  8'd40};
      {3'd4, 2'd1}: s = '{1'b0, 16'd0,    8'd20};
      {3'd4, 2'd2}: s = '{1'b1, Tone1319, 8'd60};
      {3'd5, 2'd0}: s = '{1'b1, Tone660,  8'd160};
      {3'd5, 2'd1}: s = '{1'b0, 16'd0,    8'd60};
      {3'd5, 2'd2}: s = '{1'b1, Tone880,  8'd160};
      default:      s = '{1'b0, 16'd0,    8'd0};
    endcase
    return s;
  endfunction

  function automatic void stop_track();
    is_playing = 1'b0;
    trk_now    = 3'd0;
    stage_now  = 2'd0;
    ms_count   = 8'd0;
    tone_now   = 1'b0;
  endfunction

  function automatic void enter_stage();
    stage_rec_t s;
    s = track_stage(trk_now, stage_now);
    ms_count = s.dur;
    tone_now = s.tone;
    if (s.tone) begin
      wrap_hold = s.wrap;
    end
  endfunction

  function automatic tone_result_t step_tone_model(input logic cmd, input logic [2:0] trk);
    tone_result_t r;
    logic [2:0]   nxt;
    logic [2:0]   total;
    r.accepted = 1'b0;
    if (cmd == tts_pkg::CmdPlay) begin
      if (en_reg && !is_playing && trk >= 3'd1 && trk <= 3'd5) begin
        trk_now    = trk;
        stage_now  = 2'd0;
        is_playing = 1'b1;
        enter_stage();
        r.accepted = 1'b1;
      end
    end else if (en_reg && is_playing) begin
      if (ms_count != 8'd0) begin
        ms_count = ms_count - 8'd1;
      end
      if (ms_count == 8'd0) begin
        tone_now = 1'b0;
        nxt      = {1'b0, stage_now} + 3'd1;
        total    = (trk_now == 3'd3) ? 3'd1 : 3'd3;
        if (nxt >= total || nxt > 3'd2) begin
          stop_track();
        end else begin
          stage_now = nxt[1:0];
          enter_stage();
        end
      end
    end
    r.busy    = is_playing;
    r.tone_on = tone_now;
    r.wrap    = wrap_hold;
    r.duty    = 16'(({1'b0, wrap_hold} + 17'd1) >> 1);
    return r;
  endfunction

  // prediction, checking and watchdog
  always @(posedge clk) begin
    tone_result_t got;
    tone_result_t want;
    if (!rst_n) begin
      en_reg    = 1'b0;
      wrap_hold = 16'd0;
      stop_track();
      in_taken    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        en_reg = cfg_data;
        stop_track();
      end
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        got.accepted = out_tdata[0];
        got.busy     = out_tdata[1];
        got.tone_on  = out_tdata[2];
        got.wrap     = out_tdata[18:3];
        got.duty     = out_tdata[34:19];
        if (expected_tones.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= MaxReports) begin
            $display("unexpected result acc=%0d busy=%0d tone=%0d wrap=%0d duty=%0d",
                     got.accepted, got.busy, got.tone_on, got.wrap, got.duty);
          end
        end else begin
          want = expected_tones.pop_front();
          if (got !== want) begin
            fail_count = fail_count + 1;
            if (fail_count <= MaxReports) begin
              $display("mismatch expected acc=%0d busy=%0d tone=%0d wrap=%0d duty=%0d",
                       want.accepted, want.busy, want.tone_on, want.wrap, want.duty);
              $display("         actual   acc=%0d busy=%0d tone=%0d wrap=%0d duty=%0d",
                       got.accepted, got.busy, got.tone_on, got.wrap, got.duty);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_tones.push_back(step_tone_model(in_tuser, in_tdata[2:0]));
      end
      in_taken <= in_tvalid && in_tready;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // item driver
  always @(negedge clk) begin
    play_item_t nxt_item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {5'd0, nxt_item.trk};
        in_tuser  <= nxt_item.cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic queue_item(input logic cmd, input logic [2:0] trk);
    pending_items.push_back('{cmd: cmd, trk: trk});
    items_queued = items_queued + 1;
  endtask

  task automatic wait_drained();
    while (results_seen != items_queued) @(negedge clk);
  endtask

  task automatic write_enable(input logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // a play request followed by a run of ticks, with stray requests mixed in
  task automatic queue_random_items(input int unsigned count);
    int unsigned added;
    int unsigned run_len;
    int unsigned pick;
    logic [2:0]  trk;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, 2);
        trk  = (pick == 0) ? 3'd0 : 3'(pick + 5);
      end else begin
        trk = 3'($urandom_range(1, 5));
      end
      queue_item(tts_pkg::CmdPlay, trk);
      added   = added + 1;
      run_len = $urandom_range(10, 170);
      for (int unsigned i = 0; i < run_len && added < count; i++) begin
        if ($urandom_range(0, 15) == 0) begin
          queue_item(tts_pkg::CmdPlay, 3'($urandom_range(0, 7)));
        end else begin
          queue_item(tts_pkg::CmdTick, 3'($urandom_range(0, 7)));
        end
        added = added + 1;
      end
    end
  endtask

  initial begin
    logic        phase_en[NPhases];
    int unsigned phase_send[NPhases];
    int unsigned phase_recv[NPhases];
    int unsigned phase_len[NPhases];
    phase_en   = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    phase_send = '{0, 76, 14, 0, 14};
    phase_recv = '{0, 0, 14, 76, 14};
    phase_len  = '{200, 200, 40, 200, 200};

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled after reset
    queue_item(tts_pkg::CmdTick, 3'd0);
    queue_item(tts_pkg::CmdPlay, 3'd1);
    queue_item(tts_pkg::CmdTick, 3'd7);
    wait_drained();

    write_enable(1'b1);
    queue_item(tts_pkg::CmdTick, 3'd0);
    queue_item(tts_pkg::CmdPlay, 3'd0);
    queue_item(tts_pkg::CmdPlay, 3'd6);
    queue_item(tts_pkg::CmdPlay, 3'd7);
    queue_item(tts_pkg::CmdPlay, 3'd4);
    queue_item(tts_pkg::CmdPlay, 3'd2);
    queue_item(tts_pkg::CmdTick, 3'd5);
    queue_item(tts_pkg::CmdTick, 3'd2);
    queue_item(tts_pkg::CmdPlay, 3'd3);
    queue_item(tts_pkg::CmdTick, 3'd7);
    wait_drained();

    // enable rewrite stops the running track
    write_enable(1'b1);
    queue_item(tts_pkg::CmdTick, 3'd1);
    queue_item(tts_pkg::CmdPlay, 3'd3);
    queue_item(tts_pkg::CmdPlay, 3'd5);
    queue_item(tts_pkg::CmdTick, 3'd6);
    wait_drained();

    for (int p = 0; p < NPhases; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      write_enable(phase_en[p]);
      queue_random_items(phase_len[p]);
      wait_drained();
    end

    repeat (4) @(negedge clk);
    if (fail_count == 0 && expected_tones.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
